[rtl/dpts_pkg.sv]
// shared types and codes for the dram pattern test sequencer
`timescale 1ns / 1ps

package dpts_pkg;

    // fixed widths of the beat fields
    localparam int ADDR_W     = 9;
    localparam int CFG_W      = 4;
    localparam int PHASE_W    = 3;

    typedef logic [1:0]         t_kind;
    typedef logic [1:0]         t_status;
    typedef logic [1:0]         t_sub;
    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CFG_W-1:0]   t_cfg;

    // access kinds
    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    // run status
    localparam t_status ST_IDLE = 2'd0;
    localparam t_status ST_RUN  = 2'd1;
    localparam t_status ST_PASS = 2'd2;
    localparam t_status ST_FAIL = 2'd3;

    // phases
    localparam t_phase PHASE_FIRST         = 3'd0;
    localparam t_phase PHASE_CHECKER_FIRST = 3'd2;
    localparam t_phase PHASE_MARCH_FIRST   = 3'd4;
    localparam t_phase PHASE_LAST          = 3'd5;

    // sub-pass codes, solid and checkerboard phases
    localparam t_sub SUB_WRITE    = 2'd0;
    localparam t_sub SUB_READBACK = 2'd1;
    // sub-pass codes, march phases
    localparam t_sub SUB_FILL     = 2'd0;
    localparam t_sub SUB_MARCH_WR = 2'd1;
    localparam t_sub SUB_MARCH_RD = 2'd2;
    localparam t_sub SUB_RESTORE  = 2'd3;

    // address width register
    localparam t_cfg MIN_ADDR_BITS   = 4'd7;
    localparam t_cfg RESET_ADDR_BITS = 4'd8;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    typedef struct packed {
        t_kind kind;
        logic  data;
    } t_access;

    // kind and data bit of the access at a given place in the run
    function automatic t_access access_at(t_phase phase, t_sub sub, logic col_lsb);
        t_access a;
        logic    march;
        march = phase[0];
        if (phase < PHASE_MARCH_FIRST) begin
            a.kind = (sub == SUB_WRITE) ? KIND_WRITE : KIND_READ;
            a.data = phase[0] ^ ((phase >= PHASE_CHECKER_FIRST) ? col_lsb : 1'b0);
        end else begin
            case (sub)
                SUB_FILL:     begin a.kind = KIND_WRITE; a.data = ~march; end
                SUB_MARCH_WR: begin a.kind = KIND_WRITE; a.data = march;  end
                SUB_MARCH_RD: begin a.kind = KIND_READ;  a.data = march;  end
                default:      begin a.kind = KIND_WRITE; a.data = ~march; end
            endcase
        end
        return a;
    endfunction

endpackage

[rtl/dram_pattern_test_sequencer.sv]
// dram pattern test sequencer: march-style test of a one-bit-wide dram
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_ready    i_cmd, i_read_bit
// out       source     o_out_valid / i_out_ready  access, status, phase, failure record
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_addr_bits
//
// one beat in gives one beat out; a beat is taken every cycle while the
// output register is empty or being drained, so throughput is one per clock
// and the out beat follows in the next cycle (sequencing state and output register)
// synchronous active-low reset: idle, phase 0, address width 8, no failure
// a stalled output holds its beat and blocks new input beats; cfg is always ready

module dram_pattern_test_sequencer
    import dpts_pkg::*;
#(
    parameter int MAX_ADDR_BITS = 9
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    // command / access-done beats
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_cmd,
    input  logic    i_read_bit,
    // next access and status beats
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_kind   o_access_kind,
    output t_addr   o_access_row,
    output t_addr   o_access_col,
    output logic    o_write_bit,
    output t_status o_status,
    output t_phase  o_test_phase,
    output t_addr   o_fail_row,
    output t_addr   o_fail_col,
    output logic    o_fail_expected,
    output logic    o_fail_actual,
    // address width register
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  t_cfg    i_cfg_addr_bits
);

    // counter width follows the largest array; ext width covers the 9-bit ports
    localparam int CW    = MAX_ADDR_BITS;
    localparam int EXT_W = (CW > ADDR_W) ? CW : ADDR_W;
    localparam t_cfg MAX_BITS = t_cfg'(MAX_ADDR_BITS);

    typedef logic [CW-1:0] t_cnt;

    // configuration
    t_cfg    r_addr_bits;

    // sequencing state
    t_phase  r_phase,     n_phase;
    t_sub    r_sub,       n_sub;
    t_cnt    r_row,       n_row;
    t_cnt    r_col,       n_col;
    t_kind   r_pend_kind, n_pend_kind;
    logic    r_pend_exp,  n_pend_exp;
    t_status r_status,    n_status;
    t_addr   r_fail_row,  n_fail_row;
    t_addr   r_fail_col,  n_fail_col;
    logic    r_fail_exp,  n_fail_exp;
    logic    r_fail_act,  n_fail_act;

    // output register
    logic    r_out_valid;
    t_kind   r_o_kind;
    t_addr   r_o_row;
    t_addr   r_o_col;
    logic    r_o_bit;

    logic    in_fire;
    t_cfg    eff_bits;
    logic [CW:0] size_sh;
    t_cnt    last_idx;
    logic    col_wrap, row_wrap;
    t_cnt    step_row, step_col;
    logic    step_wrapped;
    logic    ph_adv, run_done;
    t_access acc;
    logic    act;
    logic [EXT_W-1:0] row_ext, col_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // clamp the width register, then last index = 2^bits - 1
    always_comb begin
        if (r_addr_bits < MIN_ADDR_BITS) begin
            eff_bits = MIN_ADDR_BITS;
        end else if (r_addr_bits > MAX_BITS) begin
            eff_bits = MAX_BITS;
        end else begin
            eff_bits = r_addr_bits;
        end
        size_sh  = (CW+1)'(1) << eff_bits;
        last_idx = CW'(size_sh - (CW+1)'(1));
    end

    // one cell step, row-major; a counter past a shrunk size wraps too
    always_comb begin
        col_wrap     = r_col >= last_idx;
        row_wrap     = r_row >= last_idx;
        step_row     = r_row;
        step_col     = r_col + CW'(1);
        step_wrapped = 1'b0;
        if (col_wrap) begin
            step_col = '0;
            if (row_wrap) begin
                step_row     = '0;
                step_wrapped = 1'b1;
            end else begin
                step_row = r_row + CW'(1);
            end
        end
    end

    // next sequencing state for an accepted beat
    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_row       = r_row;
        n_col       = r_col;
        n_pend_kind = r_pend_kind;
        n_pend_exp  = r_pend_exp;
        n_status    = r_status;
        n_fail_row  = r_fail_row;
        n_fail_col  = r_fail_col;
        n_fail_exp  = r_fail_exp;
        n_fail_act  = r_fail_act;
        ph_adv      = 1'b0;
        run_done    = 1'b0;
        acc         = '0;

        if (i_cmd == CMD_START) begin
            // restart from the first phase, clear the failure record
            n_phase    = PHASE_FIRST;
            n_sub      = SUB_WRITE;
            n_row      = '0;
            n_col      = '0;
            n_fail_row = '0;
            n_fail_col = '0;
            n_fail_exp = 1'b0;
            n_fail_act = 1'b0;
            n_status   = ST_RUN;
            acc         = access_at(PHASE_FIRST, SUB_WRITE, 1'b0);
            n_pend_kind = acc.kind;
            n_pend_exp  = acc.data;
        end else if (r_status == ST_RUN) begin
            if (r_pend_kind == KIND_READ && i_read_bit != r_pend_exp) begin
                // first mismatch: latch the cell and stop
                row_ext     = EXT_W'(r_row);
                col_ext     = EXT_W'(r_col);
                n_fail_row  = row_ext[ADDR_W-1:0];
                n_fail_col  = col_ext[ADDR_W-1:0];
                n_fail_exp  = r_pend_exp;
                n_fail_act  = i_read_bit;
                n_status    = ST_FAIL;
                n_pend_kind = KIND_NONE;
            end else begin
                if (r_phase < PHASE_MARCH_FIRST) begin
                    // solid / checkerboard: full write pass, then full read pass
                    n_row = step_row;
                    n_col = step_col;
                    if (step_wrapped) begin
                        if (r_sub == SUB_WRITE) begin
                            n_sub = SUB_READBACK;
                        end else begin
                            n_sub  = SUB_WRITE;
                            ph_adv = 1'b1;
                        end
                    end
                end else begin
                    // march: fill pass, then write/read/restore per cell
                    case (r_sub)
                        SUB_MARCH_WR, SUB_MARCH_RD: begin
                            n_sub = r_sub + t_sub'(1);
                        end
                        SUB_FILL: begin
                            n_row = step_row;
                            n_col = step_col;
                            if (step_wrapped) begin
                                n_sub = SUB_MARCH_WR;
                            end
                        end
                        default: begin
                            n_row = step_row;
                            n_col = step_col;
                            if (step_wrapped) begin
                                n_sub  = SUB_FILL;
                                ph_adv = 1'b1;
                            end else begin
                                n_sub = SUB_MARCH_WR;
                            end
                        end
                    endcase
                end

                if (ph_adv) begin
                    if (r_phase >= PHASE_LAST) begin
                        run_done = 1'b1;
                    end else begin
                        n_phase = r_phase + t_phase'(1);
                    end
                end

                if (run_done) begin
                    n_status    = ST_PASS;
                    n_pend_kind = KIND_NONE;
                end else begin
                    acc         = access_at(n_phase, n_sub, n_col[0]);
                    n_pend_kind = acc.kind;
                    n_pend_exp  = acc.data;
                end
            end
        end
        // done beats while idle, passed or failed change nothing

        // address of the access being issued
        row_ext = EXT_W'(n_row);
        col_ext = EXT_W'(n_col);
    end

    // access fields are zero when no access is issued
    assign act = (n_status == ST_RUN) && (n_pend_kind != KIND_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_bits <= RESET_ADDR_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_addr_bits <= i_cfg_addr_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_FIRST;
            r_sub       <= SUB_WRITE;
            r_row       <= '0;
            r_col       <= '0;
            r_pend_kind <= KIND_NONE;
            r_pend_exp  <= 1'b0;
            r_status    <= ST_IDLE;
            r_fail_row  <= '0;
            r_fail_col  <= '0;
            r_fail_exp  <= 1'b0;
            r_fail_act  <= 1'b0;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pend_kind <= n_pend_kind;
            r_pend_exp  <= n_pend_exp;
            r_status    <= n_status;
            r_fail_row  <= n_fail_row;
            r_fail_col  <= n_fail_col;
            r_fail_exp  <= n_fail_exp;
            r_fail_act  <= n_fail_act;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_o_kind <= act ? n_pend_kind : KIND_NONE;
            r_o_row  <= act ? row_ext[ADDR_W-1:0] : '0;
            r_o_col  <= act ? col_ext[ADDR_W-1:0] : '0;
            r_o_bit  <= act ? n_pend_exp : 1'b0;
        end
    end

    // status, phase and failure record come straight from the state registers,
    // which only move together with the output beat
    assign o_out_valid     = r_out_valid;
    assign o_access_kind   = r_o_kind;
    assign o_access_row    = r_o_row;
    assign o_access_col    = r_o_col;
    assign o_write_bit     = r_o_bit;
    assign o_status        = r_status;
    assign o_test_phase    = r_phase;
    assign o_fail_row      = r_fail_row;
    assign o_fail_col      = r_fail_col;
    assign o_fail_expected = r_fail_exp;
    assign o_fail_actual   = r_fail_act;

endmodule
